// ===== src/regression_trendline_fit_defines.svh =====
// ----------------------------------------------------------------------------
// regression_trendline_fit_defines
// Assertion macros shared by the checker of the trendline fit block.
// ----------------------------------------------------------------------------
`ifndef REGRESSION_TRENDLINE_FIT_DEFINES_SVH
`define REGRESSION_TRENDLINE_FIT_DEFINES_SVH
// Same-cycle implication, disabled while reset is high.
`define RTF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trendline fit check failed");
// Next-cycle implication, disabled while reset is high.
`define RTF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trendline fit check failed");
`endif

// ===== src/rtf_pkg.sv =====
// ----------------------------------------------------------------------------
// rtf_pkg
// Shared constants and controller/datapath command types of the trendline fit.
// ----------------------------------------------------------------------------
package rtf_pkg;
   localparam int WINDOW_MAX_DEFAULT = 64;
   localparam int PRICE_BITS = 24;
   localparam int CSR_BITS = 7;
   localparam int OUT_BITS = 48;
   localparam int FRAC_BITS = 16;
   localparam int WINDOW_RESET = 20;

   typedef struct packed {
      logic accept;
      logic setup;
      logic const_a;
      logic const_b;
      logic pass_clear;
      logic pass_step;
      logic second;
      logic slope_start;
      logic slope_take;
      logic icpt_mul;
      logic icpt_start;
      logic icpt_take;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic short_window;
      logic single_bar;
      logic pass_done;
      logic div_done;
   } dp_status_type;
endpackage

// ===== src/rtf_req_if.sv =====
// ----------------------------------------------------------------------------
// rtf_req_if
// Request channel carrying one price bar.
// ----------------------------------------------------------------------------
interface rtf_req_if;
   import rtf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [PRICE_BITS-1:0] close_price;
   logic [PRICE_BITS-1:0] high_price;
   logic [PRICE_BITS-1:0] low_price;

   modport source (output valid, output close_price, output high_price,
                   output low_price, input ready);
   modport sink (input valid, input close_price, input high_price,
                 input low_price, output ready);
endinterface

// ===== src/rtf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rtf_rsp_if
// Response channel carrying the fitted slope and the channel intercepts.
// ----------------------------------------------------------------------------
interface rtf_rsp_if;
   import rtf_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       fit_valid;
   logic signed [OUT_BITS-1:0] line_slope;
   logic signed [OUT_BITS-1:0] support_intercept;
   logic signed [OUT_BITS-1:0] resistance_intercept;

   modport source (output valid, output fit_valid, output line_slope,
                   output support_intercept, output resistance_intercept,
                   input ready);
   modport sink (input valid, input fit_valid, input line_slope,
                 input support_intercept, input resistance_intercept,
                 output ready);
endinterface

// ===== src/rtf_ram.sv =====
// ----------------------------------------------------------------------------
// rtf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rtf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== src/rtf_div.sv =====
// ----------------------------------------------------------------------------
// rtf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtf_div #(
   parameter int DVW = 58,
   parameter int DSW = 22
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [DSW-1:0] divisor,
   output logic [DVW-1:0] quotient,
   output logic           done
);
   localparam int CNTW = $clog2(DVW + 1);

   logic [DVW-1:0]  quo_ff, quo_in;
   logic [DSW-1:0]  rem_ff, rem_in;
   logic [DSW-1:0]  dsr_ff, dsr_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [DSW:0]    trial;
   logic            fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVW-1]};
      fits    = trial >= {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNTW'(DVW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DSW'(trial - {1'b0, dsr_ff}) : trial[DSW-1:0];
         quo_in = {quo_ff[DVW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

// ===== src/rtf_datapath.sv =====
// ----------------------------------------------------------------------------
// rtf_datapath
// Bar ring, window sums, shared divider and channel search of the fit.
// ----------------------------------------------------------------------------
module rtf_datapath #(
   parameter int WINDOW_MAX = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rtf_pkg::dp_cmd_type                   cmd,
   output rtf_pkg::dp_status_type                status,
   input  logic [rtf_pkg::PRICE_BITS-1:0]        close_price,
   input  logic [rtf_pkg::PRICE_BITS-1:0]        high_price,
   input  logic [rtf_pkg::PRICE_BITS-1:0]        low_price,
   input  logic                                  csr_we,
   input  logic [rtf_pkg::CSR_BITS-1:0]          csr_wdata,
   output logic                                  fit_valid,
   output logic signed [rtf_pkg::OUT_BITS-1:0]   line_slope,
   output logic signed [rtf_pkg::OUT_BITS-1:0]   support_intercept,
   output logic signed [rtf_pkg::OUT_BITS-1:0]   resistance_intercept
);
   import rtf_pkg::*;

   localparam int AW  = $clog2(WINDOW_MAX);
   localparam int NW  = $clog2(WINDOW_MAX + 1);
   localparam int PB  = PRICE_BITS;
   localparam int DVW = 2 * NW + PB + 20;
   localparam int DSW = 3 * NW + 1;
   localparam int SW  = (DVW + 2 > OUT_BITS + 1) ? DVW + 2 : OUT_BITS + 1;
   localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(OUT_BITS-1){1'b1}}});
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

   function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] c;
      c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
      return c[OUT_BITS-1:0];
   endfunction

   logic [CSR_BITS-1:0]  win_ff;
   logic [AW-1:0]        wp_ff;
   logic [NW-1:0]        seen_ff;
   logic [NW-1:0]        n_ff;
   logic [AW-1:0]        base_ff;
   logic                 short_ff;
   logic [2*NW-1:0]      nn_ff;
   logic [2*NW-1:0]      sx_ff;
   logic [3*NW-1:0]      t_ff;
   logic [AW-1:0]        rd_ptr_ff;
   logic [NW-1:0]        cnt_ff;
   logic                 vld_ff;
   logic                 first_ff;
   logic signed [NW:0]   w_ff;
   logic signed [SW-1:0] s_ff;
   logic [NW+PB-1:0]     sum_y_ff;
   logic signed [SW-1:0] m_ff;
   logic signed [SW-1:0] prod_ff;
   logic signed [SW-1:0] b_ff;
   logic signed [SW-1:0] line_ff;
   logic signed [SW-1:0] best_hi_ff;
   logic signed [SW-1:0] best_lo_ff;
   logic                 neg_ff;

   logic [NW-1:0]        n_in;
   logic [AW-1:0]        base_in;
   logic                 issue;
   logic [3*PB-1:0]      rdata;
   logic [PB-1:0]        y_close;
   logic [PB-1:0]        y_high;
   logic [PB-1:0]        y_low;
   logic signed [SW-1:0] wy;
   logic signed [SW-1:0] dev_hi;
   logic signed [SW-1:0] dev_lo;
   logic [SW-1:0]        s_mag;
   logic signed [SW-1:0] num;
   logic [SW-1:0]        num_mag;
   logic                 div_start;
   logic [DVW-1:0]       div_x;
   logic [DSW-1:0]       div_y;
   logic [DVW-1:0]       div_q;
   logic                 div_done;
   logic signed [SW-1:0] q_signed;

   rtf_ram #(.WIDTH(3 * PB), .DEPTH(WINDOW_MAX)) u_ring (
      .clock (clock),
      .we    (cmd.accept),
      .waddr (wp_ff),
      .wdata ({close_price, high_price, low_price}),
      .raddr (rd_ptr_ff),
      .rdata (rdata)
   );

   rtf_div #(.DVW(DVW), .DSW(DSW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_x),
      .divisor  (div_y),
      .quotient (div_q),
      .done     (div_done)
   );

   always_comb begin
      n_in = (32'(win_ff) > WINDOW_MAX) ? NW'(WINDOW_MAX) : NW'(win_ff);
      base_in = (32'(wp_ff) >= 32'(n_ff)) ? AW'(32'(wp_ff) - 32'(n_ff))
                                          : AW'(32'(wp_ff) + WINDOW_MAX - 32'(n_ff));
      issue   = cmd.pass_step && (cnt_ff != n_ff);
      y_close = rdata[3*PB-1:2*PB];
      y_high  = rdata[2*PB-1:PB];
      y_low   = rdata[PB-1:0];
      wy      = SW'(w_ff) * SW'($signed({1'b0, y_close}));
      dev_hi  = SW'($signed({1'b0, y_high, {FRAC_BITS{1'b0}}})) - line_ff;
      dev_lo  = SW'($signed({1'b0, y_low, {FRAC_BITS{1'b0}}})) - line_ff;
      s_mag   = s_ff[SW-1] ? SW'(-s_ff) : SW'(s_ff);
      num     = SW'($signed({1'b0, sum_y_ff, {FRAC_BITS{1'b0}}})) - prod_ff;
      num_mag = num[SW-1] ? SW'(-num) : SW'(num);
      div_start = cmd.slope_start || cmd.icpt_start;
      if (cmd.slope_start) begin
         div_x = ((DVW'(s_mag) * DVW'(3)) << 18) + DVW'(t_ff);
         div_y = DSW'({t_ff, 1'b0});
      end else begin
         div_x = DVW'({num_mag, 1'b0}) + DVW'(n_ff);
         div_y = DSW'({n_ff, 1'b0});
      end
      q_signed = neg_ff ? -SW'(div_q) : SW'(div_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= CSR_BITS'(WINDOW_RESET);
         wp_ff    <= '0;
         seen_ff  <= '0;
         vld_ff   <= 1'b0;
         short_ff <= 1'b1;
      end else begin
         if (csr_we) begin
            win_ff <= csr_wdata;
         end
         if (cmd.accept) begin
            wp_ff <= (32'(wp_ff) == WINDOW_MAX - 1) ? '0 : wp_ff + 1'b1;
            if (32'(seen_ff) < WINDOW_MAX) begin
               seen_ff <= seen_ff + 1'b1;
            end
         end
         if (cmd.setup) begin
            short_ff <= (n_in == '0) || (seen_ff < n_in);
         end
         vld_ff <= issue && !cmd.pass_clear;
      end

      if (cmd.setup) begin
         n_ff <= n_in;
      end
      if (cmd.const_a) begin
         base_ff <= base_in;
         nn_ff   <= (2*NW)'(n_ff) * (2*NW)'(n_ff);
         sx_ff   <= ((2*NW)'(n_ff) * ((2*NW)'(n_ff) - 1'b1)) >> 1;
      end
      if (cmd.const_b) begin
         t_ff <= (3*NW)'(nn_ff) * (3*NW)'(n_ff) - (3*NW)'(n_ff);
         m_ff <= '0;
      end

      if (cmd.pass_clear) begin
         rd_ptr_ff <= base_ff;
         cnt_ff    <= '0;
         first_ff  <= 1'b1;
         w_ff      <= -$signed({1'b0, n_ff - 1'b1});
         s_ff      <= '0;
         sum_y_ff  <= '0;
      end else begin
         if (issue) begin
            rd_ptr_ff <= (32'(rd_ptr_ff) == WINDOW_MAX - 1) ? '0 : rd_ptr_ff + 1'b1;
            cnt_ff    <= cnt_ff + 1'b1;
         end
         if (vld_ff && !cmd.second) begin
            s_ff     <= s_ff + wy;
            sum_y_ff <= sum_y_ff + (NW+PB)'(y_close);
            w_ff     <= w_ff + 3'sd2;
         end
         if (vld_ff && cmd.second) begin
            first_ff <= 1'b0;
            line_ff  <= line_ff + m_ff;
            if (first_ff || (dev_hi > best_hi_ff)) begin
               best_hi_ff <= dev_hi;
            end
            if (first_ff || (dev_lo < best_lo_ff)) begin
               best_lo_ff <= dev_lo;
            end
         end
      end

      if (cmd.slope_start) begin
         neg_ff <= s_ff[SW-1];
      end else if (cmd.icpt_start) begin
         neg_ff <= num[SW-1];
      end
      if (cmd.slope_take) begin
         m_ff <= q_signed;
      end
      if (cmd.icpt_mul) begin
         prod_ff <= m_ff * SW'($signed({1'b0, sx_ff}));
      end
      if (cmd.icpt_take) begin
         b_ff    <= q_signed;
         line_ff <= q_signed;
      end

      if (cmd.out_load) begin
         if (short_ff) begin
            fit_valid            <= 1'b0;
            line_slope           <= '0;
            support_intercept    <= '0;
            resistance_intercept <= '0;
         end else begin
            fit_valid            <= 1'b1;
            line_slope           <= sat(m_ff);
            support_intercept    <= sat(best_lo_ff + b_ff);
            resistance_intercept <= sat(best_hi_ff + b_ff);
         end
      end
   end

   always_comb begin
      status.short_window = short_ff;
      status.single_bar   = (t_ff == '0);
      status.pass_done    = (cnt_ff == n_ff) && !vld_ff;
      status.div_done     = div_done;
   end
endmodule

// ===== src/rtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtf_ctrl
// Sequencer of the trendline fit: request intake, passes, divisions, response.
// ----------------------------------------------------------------------------
module rtf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output rtf_pkg::dp_cmd_type    cmd,
   input  rtf_pkg::dp_status_type status
);
   import rtf_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE       = 12'b000000000001,
      ST_SETUP      = 12'b000000000010,
      ST_CONST_A    = 12'b000000000100,
      ST_CONST_B    = 12'b000000001000,
      ST_PASS1      = 12'b000000010000,
      ST_SLOPE_GO   = 12'b000000100000,
      ST_SLOPE_WAIT = 12'b000001000000,
      ST_ICPT_MUL   = 12'b000010000000,
      ST_ICPT_GO    = 12'b000100000000,
      ST_ICPT_WAIT  = 12'b001000000000,
      ST_PASS2      = 12'b010000000000,
      ST_OUTPUT     = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_CONST_A;
         end
         ST_CONST_A: begin
            cmd.const_a = 1'b1;
            state_in    = status.short_window ? ST_OUTPUT : ST_CONST_B;
         end
         ST_CONST_B: begin
            cmd.const_b    = 1'b1;
            cmd.pass_clear = 1'b1;
            state_in       = ST_PASS1;
         end
         ST_PASS1: begin
            cmd.pass_step = 1'b1;
            if (status.pass_done) begin
               state_in = status.single_bar ? ST_ICPT_MUL : ST_SLOPE_GO;
            end
         end
         ST_SLOPE_GO: begin
            cmd.slope_start = 1'b1;
            state_in        = ST_SLOPE_WAIT;
         end
         ST_SLOPE_WAIT: begin
            if (status.div_done) begin
               cmd.slope_take = 1'b1;
               state_in       = ST_ICPT_MUL;
            end
         end
         ST_ICPT_MUL: begin
            cmd.icpt_mul = 1'b1;
            state_in     = ST_ICPT_GO;
         end
         ST_ICPT_GO: begin
            cmd.icpt_start = 1'b1;
            state_in       = ST_ICPT_WAIT;
         end
         ST_ICPT_WAIT: begin
            if (status.div_done) begin
               cmd.icpt_take  = 1'b1;
               cmd.pass_clear = 1'b1;
               cmd.second     = 1'b1;
               state_in       = ST_PASS2;
            end
         end
         ST_PASS2: begin
            cmd.pass_step = 1'b1;
            cmd.second    = 1'b1;
            if (status.pass_done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ===== src/regression_trendline_fit.sv =====
// ----------------------------------------------------------------------------
// regression_trendline_fit
// Least-squares channel over a sliding window of price bars.
// ----------------------------------------------------------------------------
// Each request stores one bar and yields one response. Two passes over the
// bar ring read one bar per cycle, and the slope and the intercept each go
// through the shared divider, which retires one quotient bit per cycle. A
// window of one bar skips the slope division. A response that waits in its
// output register does not hold back the next request. While fewer than N
// bars are stored, the response skips the passes and divisions and carries
// all zeros.
// ----------------------------------------------------------------------------
module regression_trendline_fit #(
   parameter int WINDOW_MAX = rtf_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   rtf_req_if.sink                       req,
   rtf_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [rtf_pkg::CSR_BITS-1:0]  csr_wdata
);
   import rtf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .cmd       (cmd),
      .status    (status)
   );

   rtf_datapath #(.WINDOW_MAX(WINDOW_MAX)) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .close_price          (req.close_price),
      .high_price           (req.high_price),
      .low_price            (req.low_price),
      .csr_we               (csr_we),
      .csr_wdata            (csr_wdata),
      .fit_valid            (rsp.fit_valid),
      .line_slope           (rsp.line_slope),
      .support_intercept    (rsp.support_intercept),
      .resistance_intercept (rsp.resistance_intercept)
   );
endmodule

// ===== src/rtf_checker.sv =====
// ----------------------------------------------------------------------------
// rtf_checker
// Port-level checks of the trendline fit, bound to the top level.
// ----------------------------------------------------------------------------
`include "regression_trendline_fit_defines.svh"

module rtf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                fit_valid,
   input logic signed [rtf_pkg::OUT_BITS-1:0] line_slope,
   input logic signed [rtf_pkg::OUT_BITS-1:0] support_intercept,
   input logic signed [rtf_pkg::OUT_BITS-1:0] resistance_intercept
);
   `RTF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `RTF_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   `RTF_ASSERT_IMP(a_zero_when_short, clock, reset, rsp_valid && !fit_valid, (line_slope == '0) && (support_intercept == '0) && (resistance_intercept == '0))
endmodule

bind regression_trendline_fit rtf_checker u_rtf_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req.valid),
   .req_ready            (req.ready),
   .rsp_valid            (rsp.valid),
   .rsp_ready            (rsp.ready),
   .fit_valid            (rsp.fit_valid),
   .line_slope           (rsp.line_slope),
   .support_intercept    (rsp.support_intercept),
   .resistance_intercept (rsp.resistance_intercept)
);

// ===== sim/tb_regression_trendline_fit.sv =====
// ----------------------------------------------------------------------------
// tb_regression_trendline_fit
// Self-checking testbench for the least-squares trendline channel.
// ----------------------------------------------------------------------------
// Price bars are sent as requests, and an internal predictor tracks the bar
// history and window length to compute each expected fit. Responses are
// checked in order, field by field. The run covers directed extremes, chosen
// window settings including zero, one and the oversize values, backpressure and
// random idle gaps on both channels, and random trending and noisy bars.
// ----------------------------------------------------------------------------
module tb_regression_trendline_fit;
   import rtf_pkg::*;

   localparam int RING_DEPTH = 64;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 900;
   localparam int DRAIN_CYCLES = 400;

   typedef logic [PRICE_BITS-1:0] price_type;
   typedef logic signed [OUT_BITS-1:0] q16_type;

   typedef struct {
      logic fit_valid;
      q16_type line_slope;
      q16_type support_intercept;
      q16_type resistance_intercept;
   } channel_fit_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_BITS-1:0] csr_wdata;

   rtf_req_if req_if ();
   rtf_rsp_if rsp_if ();

   regression_trendline_fit DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if.sink),
      .rsp       (rsp_if.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   price_type close_hist[RING_DEPTH];
   price_type high_hist[RING_DEPTH];
   price_type low_hist[RING_DEPTH];
   int hist_ptr;
   int bars_stored;
   logic [CSR_BITS-1:0] window_cfg;

   channel_fit_type pending_fits[$];
   int errors;
   int requests_sent;
   int responses_seen;
   int idle_count;
   bit gaps_on;
   bit hold_rsp;
   int walk_level;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint round_div(longint num, longint unsigned d);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = (2 * mag + d) / (2 * d);
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic q16_type clamp48(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< 47) - 1;
      lo = -(longint'(1) <<< 47);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[OUT_BITS-1:0];
   endfunction

   // Stores the bar and returns the channel over the current window.
   function automatic channel_fit_type fit_channel(price_type c, price_type h, price_type l);
      channel_fit_type fit;
      int n;
      int base;
      int slot;
      int up;
      int dn;
      longint s;
      longint m;
      longint b;
      longint line_val;
      longint dev;
      longint best_hi;
      longint best_lo;
      longint unsigned d;
      longint unsigned a;
      longint unsigned q;
      longint unsigned r;
      longint unsigned mag;
      longint unsigned sum_y;
      longint unsigned sum_x;
      close_hist[hist_ptr] = c;
      high_hist[hist_ptr] = h;
      low_hist[hist_ptr] = l;
      hist_ptr = (hist_ptr + 1) % RING_DEPTH;
      if (bars_stored < RING_DEPTH) bars_stored++;
      fit = '{1'b0, '0, '0, '0};
      n = (window_cfg > RING_DEPTH) ? RING_DEPTH : int'(window_cfg);
      if (n == 0 || bars_stored < n) return fit;
      base = (hist_ptr + RING_DEPTH - n) % RING_DEPTH;
      s = 0;
      sum_y = 0;
      for (int i = 0; i < n; i++) begin
         slot = (base + i) % RING_DEPTH;
         s += (2 * longint'(i) - longint'(n - 1)) * longint'(close_hist[slot]);
         sum_y += close_hist[slot];
      end
      d = longint'(n) * (longint'(n) * n - 1) / 3;
      if (d == 0) begin
         m = 0;
      end else begin
         a = 2 * ((s < 0) ? longint'(-s) : longint'(s));
         q = a / d;
         r = a % d;
         mag = (q << FRAC_BITS) + ((r << (FRAC_BITS + 1)) + d) / (2 * d);
         m = (s < 0) ? -longint'(mag) : longint'(mag);
      end
      sum_x = longint'(n) * (n - 1) / 2;
      b = round_div(longint'(sum_y << FRAC_BITS) - m * longint'(sum_x), n);
      up = 0;
      dn = 0;
      best_hi = 0;
      best_lo = 0;
      for (int i = 0; i < n; i++) begin
         slot = (base + i) % RING_DEPTH;
         line_val = m * i + b;
         dev = (longint'(high_hist[slot]) <<< FRAC_BITS) - line_val;
         if (i == 0 || dev > best_hi) begin
            best_hi = dev;
            up = i;
         end
         dev = (longint'(low_hist[slot]) <<< FRAC_BITS) - line_val;
         if (i == 0 || dev < best_lo) begin
            best_lo = dev;
            dn = i;
         end
      end
      fit.fit_valid = 1'b1;
      fit.line_slope = clamp48(m);
      fit.support_intercept = clamp48((longint'(low_hist[(base + dn) % RING_DEPTH])
                                       <<< FRAC_BITS) - m * dn);
      fit.resistance_intercept = clamp48((longint'(high_hist[(base + up) % RING_DEPTH])
                                          <<< FRAC_BITS) - m * up);
      return fit;
   endfunction

   task automatic send_bar(price_type c, price_type h, price_type l);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.close_price <= c;
      req_if.high_price <= h;
      req_if.low_price <= l;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_fits.push_back(fit_channel(c, h, l));
      requests_sent++;
   endtask

   // Mostly a bounded random walk so the fits see real trends, sometimes noise.
   task automatic send_random_bar();
      int c;
      int h;
      int l;
      if ($urandom_range(0, 4) == 0) begin
         send_bar(PRICE_BITS'($urandom), PRICE_BITS'($urandom), PRICE_BITS'($urandom));
      end else begin
         walk_level += int'($urandom_range(0, 2000)) - 1000;
         if (walk_level < 4000 || walk_level > 16_770_000) begin
            walk_level = int'($urandom_range(4000, 16_770_000));
         end
         c = walk_level;
         h = c + int'($urandom_range(0, 3000));
         l = c - int'($urandom_range(0, 3000));
         if (h > 24'hFFFFFF) h = 24'hFFFFFF;
         send_bar(PRICE_BITS'(c), PRICE_BITS'(h), PRICE_BITS'(l));
      end
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_fits.size() != 0) @(posedge clock);
   endtask

   task automatic set_window(logic [CSR_BITS-1:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      window_cfg = value;
      csr_we <= 1'b0;
   endtask

   task automatic test_directed_extremes();
      for (int i = 0; i < 8; i++) send_bar('0, '0, '0);
      for (int i = 0; i < 8; i++) send_bar('1, '1, '1);
      // Equal highs and lows on a flat close make every bar tie for the pivot.
      for (int i = 0; i < 6; i++) send_bar(24'h800000, 24'h800100, 24'h7FFF00);
      send_bar('0, '1, '0);
      send_bar('1, '0, '1);
   endtask

   task automatic test_window_settings();
      logic [CSR_BITS-1:0] settings[7] = '{7'd1, 7'd2, 7'd0, 7'd64, 7'd127, 7'd3, 7'd65};
      foreach (settings[k]) begin
         set_window(settings[k]);
         for (int i = 0; i < 30; i++) send_random_bar();
      end
      set_window(7'd2);
      send_bar('1, '1, '1);
      send_bar('0, '0, '0);
      send_bar('1, '1, '0);
   endtask

   task automatic test_backpressure();
      set_window(7'd8);
      hold_rsp = 1'b1;
      for (int i = 0; i < 12; i++) send_random_bar();
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 10; i++) send_random_bar();
      wait_drained();
      for (int i = 0; i < 10; i++) send_random_bar();
   endtask

   task automatic test_random_windows();
      for (int p = 0; p < 6; p++) begin
         set_window(($urandom_range(0, 3) == 0) ? CSR_BITS'($urandom_range(0, 127))
                                                : CSR_BITS'($urandom_range(1, 24)));
         for (int i = 0; i < 15; i++) send_random_bar();
      end
   endtask

   task automatic test_no_gaps();
      gaps_on = 1'b0;
      set_window(7'd20);
      for (int i = 0; i < 40; i++) send_random_bar();
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.close_price <= '0;
      req_if.high_price <= '0;
      req_if.low_price <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      errors = 0;
      requests_sent = 0;
      responses_seen = 0;
      gaps_on = 1'b1;
      hold_rsp = 1'b0;
      walk_level = 8_000_000;
      hist_ptr = 0;
      bars_stored = 0;
      window_cfg = WINDOW_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_window_settings();
      test_backpressure();
      test_drain_pause();
      test_random_windows();
      test_no_gaps();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d bars over window lengths 0 to 127, checked %0d fits,",
               requests_sent, responses_seen);
      $display("with idle bursts, a long response hold-off and a full drain pause.");
      if (errors == 0 && pending_fits.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (gaps_on && $urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      channel_fit_type exp_fit;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         responses_seen++;
         if (pending_fits.size() == 0) begin
            $error("Response with no request outstanding");
            errors++;
         end else begin
            exp_fit = pending_fits.pop_front();
            if (rsp_if.fit_valid !== exp_fit.fit_valid) begin
               $error("fit_valid: expected %0d, actual %0d",
                      exp_fit.fit_valid, rsp_if.fit_valid);
               errors++;
            end
            if (rsp_if.line_slope !== exp_fit.line_slope) begin
               $error("line_slope: expected %0d, actual %0d",
                      exp_fit.line_slope, rsp_if.line_slope);
               errors++;
            end
            if (rsp_if.support_intercept !== exp_fit.support_intercept) begin
               $error("support_intercept: expected %0d, actual %0d",
                      exp_fit.support_intercept, rsp_if.support_intercept);
               errors++;
            end
            if (rsp_if.resistance_intercept !== exp_fit.resistance_intercept) begin
               $error("resistance_intercept: expected %0d, actual %0d",
                      exp_fit.resistance_intercept, rsp_if.resistance_intercept);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
         $display("Timeout with %0d responses outstanding", pending_fits.size());
         $display("Mismatches found");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end
endmodule

// ===== sim.f =====
+incdir+src
src/rtf_pkg.sv
src/rtf_req_if.sv
src/rtf_rsp_if.sv
src/rtf_ram.sv
src/rtf_div.sv
src/rtf_datapath.sv
src/rtf_ctrl.sv
src/regression_trendline_fit.sv
src/rtf_checker.sv
sim/tb_regression_trendline_fit.sv
